/* sv/mprt_pkg.sv */
// Shared types and constants of the masked priority route table.
package mprt_pkg;

   // Number of output ports this node has; port fields are three bits wide.
   localparam int PORTS = 8;

   // Ports that physically exist, one bit per port.
   localparam logic [7:0] PORT_PRESENT_MASK =
      (PORTS >= 8) ? 8'hFF : 8'((9'd1 << PORTS) - 9'd1);

   // A rule priority of this value is stored but never selected.
   localparam logic [7:0] NO_PRIORITY = 8'hFF;

   typedef enum logic [1:0] {
      FUNC_ROUTE   = 2'd0,
      FUNC_ADD     = 2'd1,
      FUNC_SET_PRI = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ACT_DISCARD   = 3'd0,
      ACT_LOCAL     = 3'd1,
      ACT_BROADCAST = 3'd2,
      ACT_UNICAST   = 3'd3,
      ACT_NO_ROUTE  = 3'd4,
      ACT_DONE      = 3'd5,
      ACT_ERROR     = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      CSR_OWN_ADDR   = 2'd0,
      CSR_ALIAS_ADDR = 2'd1,
      CSR_BCAST_ADDR = 2'd2,
      CSR_PORT_EN    = 2'd3
   } csr_index_type;

   // Which result the output register takes.
   typedef enum logic [2:0] {
      RES_ERROR   = 3'd0,
      RES_LOCAL   = 3'd1,
      RES_BCAST   = 3'd2,
      RES_ROUTE   = 3'd3,
      RES_ADD     = 3'd4,
      RES_SET_PRI = 3'd5
   } res_sel_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [15:0] mask;
      logic        src_is_local;
      logic [2:0]  src_port;
      logic [2:0]  rule_port;
      logic [7:0]  priority_req;
      logic [3:0]  rule_index;
   } item_type;

   typedef struct packed {
      action_type  action;
      logic [2:0]  out_port;
      logic [7:0]  port_mask;
      logic [3:0]  slot;
   } result_type;

   typedef struct packed {
      logic        load;
      logic        scan_clear;
      logic        scan_step;
      logic        add_write;
      logic        pri_write;
      logic        out_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     addr_local;
      logic     addr_bcast;
      logic     pri_slot_ok;
      logic     free_hit;
      logic     idx_end;
      logic     scan_done;
      logic     out_free;
   } status_type;

endpackage

/* sv/masked_priority_route_table_unit.sv */
// Top level of the masked priority route table: stream ports, settings port, sequencer, datapath.
// Order of work: a local, broadcast, set-priority or unused-selector word is decoded and its
// result registered; a table route scans every rule first; an add scans up to the first free slot.
// Throughput: one word at a time; a table route is held for the whole one-rule-per-cycle scan
// over the single read port of the rule memory.
// Reset (synchronous, active high) empties the table and restores the address settings.
module masked_priority_route_table_unit #(
   parameter int ROUTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: address[15:0], mask[15:0], src_is_local, src_port[2:0],
   // rule_port[2:0], priority_req[7:0], rule_index[3:0], zero fill to 56 bits.
   input  logic [55:0] req_tdata,
   // tuser: func[1:0].
   input  logic [1:0]  req_tuser,
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: out_port[2:0], port_mask[7:0], slot[3:0], one zero bit.
   output logic [15:0] rsp_tdata,
   // tuser: action[2:0].
   output logic [2:0]  rsp_tuser,
   // Settings write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   mprt_pkg::cmd_type    cmd;
   mprt_pkg::status_type status;
   mprt_pkg::item_type   req_item;
   mprt_pkg::result_type rsp_result;

   // Unpack the request word into its fields.
   assign req_item.func         = req_tuser;
   assign req_item.address      = req_tdata[15:0];
   assign req_item.mask         = req_tdata[31:16];
   assign req_item.src_is_local = req_tdata[32];
   assign req_item.src_port     = req_tdata[35:33];
   assign req_item.rule_port    = req_tdata[38:36];
   assign req_item.priority_req = req_tdata[46:39];
   assign req_item.rule_index   = req_tdata[50:47];

   // The sequencer accepts a request only when it is idle. The result register in the
   // datapath lets the next request start while an earlier result is still waiting.
   mprt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the settings, the rule memories with their valid bits, the
   // running best match of a scan, and the response register.
   mprt_dpath #(
      .ROUTES (ROUTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   // Pack the response word.
   assign rsp_tdata = {1'b0, rsp_result.slot, rsp_result.port_mask, rsp_result.out_port};
   assign rsp_tuser = rsp_result.action;

endmodule

/* sv/mprt_ctrl.sv */
// Sequencing state machine of the route table: decode, table scans and result hand-off.
module mprt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mprt_pkg::status_type status,
   output mprt_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE       = 4'b0001,
      S_DECODE     = 4'b0010,
      S_ROUTE_SCAN = 4'b0100,
      S_ADD_SCAN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.res_sel = mprt_pkg::RES_ERROR;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               mprt_pkg::FUNC_ROUTE: begin
                  // The local check wins over broadcast when both addresses agree.
                  priority if (status.addr_local) begin
                     if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res_sel  = mprt_pkg::RES_LOCAL;
                        state_in     = S_IDLE;
                     end
                  end else if (status.addr_bcast) begin
                     if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res_sel  = mprt_pkg::RES_BCAST;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_ROUTE_SCAN;
                  end
               end
               mprt_pkg::FUNC_ADD: begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_ADD_SCAN;
               end
               mprt_pkg::FUNC_SET_PRI: begin
                  if (status.out_free) begin
                     cmd.out_load  = 1'b1;
                     cmd.pri_write = status.pri_slot_ok;
                     cmd.res_sel   = status.pri_slot_ok ? mprt_pkg::RES_SET_PRI
                                                        : mprt_pkg::RES_ERROR;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.res_sel  = mprt_pkg::RES_ERROR;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_ROUTE_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done && status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.res_sel  = mprt_pkg::RES_ROUTE;
               state_in     = S_IDLE;
            end
         end
         S_ADD_SCAN: begin
            priority if (status.free_hit) begin
               if (status.out_free) begin
                  cmd.add_write = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.res_sel   = mprt_pkg::RES_ADD;
                  state_in      = S_IDLE;
               end
            end else if (status.idx_end) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.res_sel  = mprt_pkg::RES_ERROR;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/mprt_dpath.sv */
// Datapath of the route table: settings, rule memories, scan evaluation and result register.
module mprt_dpath #(
   parameter int ROUTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mprt_pkg::cmd_type    cmd,
   output mprt_pkg::status_type status,
   input  mprt_pkg::item_type   req_item,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output mprt_pkg::result_type rsp_result
);

   localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam int CW = $clog2(ROUTES + 1);
   localparam logic [CW-1:0] IDX_END = CW'(ROUTES);
   localparam logic [6:0] ROUTES_W = 7'(ROUTES);

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] mask;
      logic [2:0]  port;
   } rule_type;

   // Settings.
   logic [15:0] own_addr_ff, alias_addr_ff, bcast_addr_ff;
   logic [7:0]  port_en_ff;

   // Item under work.
   mprt_pkg::item_type item_ff;

   // Rule storage; contents are only looked at for valid slots.
   rule_type            rule_mem [ROUTES];
   logic [7:0]          pri_mem  [ROUTES];
   logic [ROUTES-1:0]   valid_ff;

   // Scan state.
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff;
   logic          rd_rule_valid_ff;
   rule_type      rule_rd_ff;
   logic [7:0]    pri_rd_ff;
   logic [7:0]    best_ff;
   logic [2:0]    best_port_ff;
   logic          found_ff;

   // Result register.
   logic                 out_vld_ff;
   mprt_pkg::result_type out_ff, out_in;

   logic [IW-1:0] idx_lo, ridx_idx, pri_waddr;
   logic          idx_end, rd_issue, hit, port_ok, pri_we;
   logic [2:0]    rd_port;
   logic [7:0]    src_bit, bcast_mask;

   assign idx_lo   = idx_ff[IW-1:0];
   assign ridx_idx = IW'(item_ff.rule_index);
   assign idx_end  = (idx_ff == IDX_END);
   assign rd_issue = cmd.scan_step && !idx_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff   <= 16'd257;
         alias_addr_ff <= 16'd0;
         bcast_addr_ff <= 16'hFFFF;
         port_en_ff    <= 8'd0;
      end else if (csr_we) begin
         unique case (mprt_pkg::csr_index_type'(csr_index))
            mprt_pkg::CSR_OWN_ADDR:   own_addr_ff   <= csr_wdata;
            mprt_pkg::CSR_ALIAS_ADDR: alias_addr_ff <= csr_wdata;
            mprt_pkg::CSR_BCAST_ADDR: bcast_addr_ff <= csr_wdata;
            mprt_pkg::CSR_PORT_EN:    port_en_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
   end

   // Memory writes and the registered scan read.
   assign pri_we    = cmd.add_write || cmd.pri_write;
   assign pri_waddr = cmd.add_write ? idx_lo : ridx_idx;

   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         rule_mem[idx_lo] <= '{address: item_ff.address, mask: item_ff.mask,
                               port: item_ff.rule_port};
      end
      if (pri_we) begin
         pri_mem[pri_waddr] <= item_ff.priority_req;
      end
      if (rd_issue) begin
         rule_rd_ff <= rule_mem[idx_lo];
         pri_rd_ff  <= pri_mem[idx_lo];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.add_write) begin
         valid_ff[idx_lo] <= 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_clear) begin
         idx_in = '0;
      end else if (rd_issue) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   // Candidate check on the rule read in the previous cycle.
   assign rd_port = rule_rd_ff.port;
   assign port_ok = mprt_pkg::PORT_PRESENT_MASK[rd_port] && port_en_ff[rd_port] &&
                    (item_ff.src_is_local || (rd_port != item_ff.src_port));
   assign hit     = rd_vld_ff && rd_rule_valid_ff &&
                    ((rule_rd_ff.mask & rule_rd_ff.address) ==
                     (rule_rd_ff.mask & item_ff.address)) &&
                    (pri_rd_ff < best_ff) && port_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff           <= '0;
         rd_vld_ff        <= 1'b0;
         rd_rule_valid_ff <= 1'b0;
         found_ff         <= 1'b0;
         best_ff          <= mprt_pkg::NO_PRIORITY;
         best_port_ff     <= 3'd0;
      end else begin
         idx_ff           <= idx_in;
         rd_vld_ff        <= rd_issue && !cmd.scan_clear;
         rd_rule_valid_ff <= valid_ff[idx_lo];
         if (cmd.scan_clear) begin
            found_ff     <= 1'b0;
            best_ff      <= mprt_pkg::NO_PRIORITY;
            best_port_ff <= 3'd0;
         end else if (hit) begin
            found_ff     <= 1'b1;
            best_ff      <= pri_rd_ff;
            best_port_ff <= rd_port;
         end
      end
   end

   // Result formation.
   assign src_bit    = item_ff.src_is_local ? 8'd0 : (8'd1 << item_ff.src_port);
   assign bcast_mask = port_en_ff & mprt_pkg::PORT_PRESENT_MASK & ~src_bit;

   always_comb begin
      out_in = '{action: mprt_pkg::ACT_ERROR, out_port: 3'd0, port_mask: 8'd0,
                 slot: 4'd0};
      case (cmd.res_sel)
         mprt_pkg::RES_LOCAL: begin
            out_in.action = item_ff.src_is_local ? mprt_pkg::ACT_LOCAL
                                                 : mprt_pkg::ACT_DISCARD;
         end
         mprt_pkg::RES_BCAST: begin
            out_in.action    = mprt_pkg::ACT_BROADCAST;
            out_in.port_mask = bcast_mask;
         end
         mprt_pkg::RES_ROUTE: begin
            if (found_ff) begin
               out_in.action   = mprt_pkg::ACT_UNICAST;
               out_in.out_port = best_port_ff;
            end else begin
               out_in.action = mprt_pkg::ACT_NO_ROUTE;
            end
         end
         mprt_pkg::RES_ADD: begin
            out_in.action = mprt_pkg::ACT_DONE;
            out_in.slot   = 4'(idx_ff);
         end
         mprt_pkg::RES_SET_PRI: begin
            out_in.action = mprt_pkg::ACT_DONE;
            out_in.slot   = item_ff.rule_index;
         end
         default: begin
            out_in.action = mprt_pkg::ACT_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_result = out_ff;

   // Status back to the sequencer.
   assign status.func        = mprt_pkg::func_type'(item_ff.func);
   assign status.addr_local  = (item_ff.address == alias_addr_ff) ||
                               (item_ff.address == own_addr_ff);
   assign status.addr_bcast  = (item_ff.address == bcast_addr_ff);
   assign status.pri_slot_ok = ({3'b000, item_ff.rule_index} < ROUTES_W) &&
                               valid_ff[ridx_idx];
   assign status.free_hit    = !idx_end && !valid_ff[idx_lo];
   assign status.idx_end     = idx_end;
   assign status.scan_done   = idx_end && !rd_vld_ff;
   assign status.out_free    = !out_vld_ff || rsp_tready;

endmodule

/* sv/mprt_checker.sv */
// Port-level checks on the route table top level, bound to every instance of it.
module mprt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A stalled response word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // Reset empties the response register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // One word is worked on at a time: acceptance closes the request side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // Only a finished table operation reports a slot.
   a_slot_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 3'(mprt_pkg::ACT_DONE)) |-> rsp_tdata[14:11] == 4'd0)
      else $error("slot reported on a non-table result");

   // A unicast result names no broadcast ports.
   a_unicast_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 3'(mprt_pkg::ACT_UNICAST)) |-> rsp_tdata[10:3] == 8'd0)
      else $error("unicast result carries a port mask");

endmodule

bind masked_priority_route_table_unit mprt_checker u_mprt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/mprt_route_checker.sv */
// Watches the route table streams, predicts every response word and compares it.
module mprt_route_checker
   import mprt_pkg::*;
#(
   parameter int ROUTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHOWN_MISMATCHES = 10;

   logic [15:0] own_addr_q;
   logic [15:0] alias_addr_q;
   logic [15:0] bcast_addr_q;
   logic [7:0]  port_en_q;

   logic        route_used [ROUTES];
   logic [15:0] route_addr [ROUTES];
   logic [15:0] route_mask [ROUTES];
   logic [2:0]  route_port [ROUTES];
   logic [7:0]  route_pri  [ROUTES];

   result_type  expected_rsp_q [$];
   int          failures = 0;

   // Applies one request word to the table copy and returns the response it must produce.
   function automatic result_type apply_request(item_type w);
      result_type  r;
      logic [7:0]  ports;
      logic [7:0]  best;
      logic        found;
      logic [2:0]  chosen;
      bit          placed;
      r = '{action: ACT_ERROR, out_port: 3'd0, port_mask: 8'd0, slot: 4'd0};
      case (w.func)
         FUNC_ROUTE: begin
            if (w.address == alias_addr_q || w.address == own_addr_q) begin
               r.action = w.src_is_local ? ACT_LOCAL : ACT_DISCARD;
            end else if (w.address == bcast_addr_q) begin
               ports = port_en_q & PORT_PRESENT_MASK;
               if (!w.src_is_local) ports &= ~(8'd1 << w.src_port);
               r.action    = ACT_BROADCAST;
               r.port_mask = ports;
            end else begin
               best   = NO_PRIORITY;
               found  = 1'b0;
               chosen = 3'd0;
               for (int i = 0; i < ROUTES; i++) begin
                  if (!route_used[i]) continue;
                  if ((route_mask[i] & route_addr[i]) != (route_mask[i] & w.address)) continue;
                  if (route_pri[i] >= best) continue;
                  if (int'(route_port[i]) >= PORTS || !port_en_q[route_port[i]]) continue;
                  if (!w.src_is_local && route_port[i] == w.src_port) continue;
                  best   = route_pri[i];
                  chosen = route_port[i];
                  found  = 1'b1;
               end
               if (found) begin
                  r.action   = ACT_UNICAST;
                  r.out_port = chosen;
               end else begin
                  r.action = ACT_NO_ROUTE;
               end
            end
         end
         FUNC_ADD: begin
            placed = 0;
            for (int i = 0; i < ROUTES; i++) begin
               if (!placed && !route_used[i]) begin
                  placed        = 1;
                  route_used[i] = 1'b1;
                  route_addr[i] = w.address;
                  route_mask[i] = w.mask;
                  route_port[i] = w.rule_port;
                  route_pri[i]  = w.priority_req;
                  r.action      = ACT_DONE;
                  r.slot        = 4'(i);
               end
            end
         end
         FUNC_SET_PRI: begin
            if (int'(w.rule_index) < ROUTES && route_used[w.rule_index]) begin
               route_pri[w.rule_index] = w.priority_req;
               r.action = ACT_DONE;
               r.slot   = w.rule_index;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(string what, result_type want, result_type got);
      failures++;
      if (failures <= SHOWN_MISMATCHES)
         $display("%t mprt_route_checker: %s: expected action %0d port %0d mask %02h slot %0d,",
                  $realtime, what, want.action, want.out_port, want.port_mask, want.slot,
                  " got action %0d port %0d mask %02h slot %0d",
                  got.action, got.out_port, got.port_mask, got.slot);
   endtask

   always @(posedge clock) begin
      item_type   req_word;
      result_type got;
      result_type want;
      if (reset) begin
         own_addr_q   = 16'd257;
         alias_addr_q = 16'd0;
         bcast_addr_q = 16'hFFFF;
         port_en_q    = 8'd0;
         for (int i = 0; i < ROUTES; i++) route_used[i] = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_ADDR:   own_addr_q   = csr_wdata;
               CSR_ALIAS_ADDR: alias_addr_q = csr_wdata;
               CSR_BCAST_ADDR: bcast_addr_q = csr_wdata;
               CSR_PORT_EN:    port_en_q    = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            req_word.func         = func_type'(req_tuser);
            req_word.address      = req_tdata[15:0];
            req_word.mask         = req_tdata[31:16];
            req_word.src_is_local = req_tdata[32];
            req_word.src_port     = req_tdata[35:33];
            req_word.rule_port    = req_tdata[38:36];
            req_word.priority_req = req_tdata[46:39];
            req_word.rule_index   = req_tdata[50:47];
            expected_rsp_q.push_back(apply_request(req_word));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.action    = action_type'(rsp_tuser);
            got.out_port  = rsp_tdata[2:0];
            got.port_mask = rsp_tdata[10:3];
            got.slot      = rsp_tdata[14:11];
            if (expected_rsp_q.size() == 0) begin
               want = '0;
               report("response with nothing outstanding", want, got);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.action != want.action || got.out_port != want.out_port ||
                   got.port_mask != want.port_mask || got.slot != want.slot)
                  report("response mismatch", want, got);
            end
         end
      end
      pending    <= expected_rsp_q.size();
      fail_count <= failures;
   end

endmodule

/* tb/sv/tb_top.sv */
// Stimulus and verdict for the masked priority route table unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mprt_pkg::*;

   localparam int ROUTE_SLOTS = 16;
   // The request selector value that names no operation.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 285;
   // Length of the long receiver hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int pending;

   // Idle rates in percent for the two sides, changed per phase by the stimulus.
   int tx_idle_pct = 15;
   int rx_idle_pct = 57;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit rx_hold_go = 0;

   // Copies of the address settings, so that routed words can aim at them.
   logic [15:0] cfg_own = 16'd257;
   logic [15:0] cfg_alias = 16'd0;
   logic [15:0] cfg_bcast = 16'hFFFF;
   // Rule addresses offered so far; routed words are often drawn near them.
   logic [15:0] rule_addr_pool [$];
   int adds_sent = 0;

   always #6 clock = ~clock;

   masked_priority_route_table_unit #(.ROUTES(ROUTE_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mprt_route_checker #(.ROUTES(ROUTE_SLOTS)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offers one request word, idling first at the sender's current rate. The task returns
   // at the edge where the word was taken, with tvalid still high, so back-to-back words
   // never drop tvalid in between.
   task automatic send_word(input logic [1:0] func, input logic [15:0] address,
                            input logic [15:0] mask, input logic src_local,
                            input logic [2:0] src_port, input logic [2:0] rule_port,
                            input logic [7:0] pri, input logic [3:0] rule_index);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'd0, rule_index, pri, rule_port, src_port, src_local, mask, address};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering words and waits until every outstanding response word has come back.
   // The checker updates its count after the edge, so at least one edge passes first.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all four settings while the unit is idle; the write enable stays high across
   // the four writes and is lowered once at the end.
   task automatic program_settings(input logic [15:0] own, input logic [15:0] alias_addr,
                                   input logic [15:0] bcast, input logic [7:0] port_en);
      drain();
      csr_we <= 1'b1;
      write_reg(CSR_OWN_ADDR, own);
      write_reg(CSR_ALIAS_ADDR, alias_addr);
      write_reg(CSR_BCAST_ADDR, bcast);
      write_reg(CSR_PORT_EN, {8'd0, port_en});
      csr_we    <= 1'b0;
      cfg_own   = own;
      cfg_alias = alias_addr;
      cfg_bcast = bcast;
   endtask

   // One random request word. Most words route packets, aimed at the settings addresses
   // or close to rule addresses so that matches, ties and exclusions happen often. Adds
   // are frequent until the table has been filled, then rare; unused selectors are noise.
   task automatic random_word();
      logic [1:0]  func;
      logic [15:0] address;
      logic [15:0] mask;
      logic        src_local;
      logic [2:0]  src_port;
      logic [2:0]  rule_port;
      logic [7:0]  pri;
      logic [3:0]  rule_index;
      int          add_pct;
      int          pick;
      address    = 16'($urandom);
      mask       = 16'($urandom);
      src_local  = 1'($urandom);
      src_port   = 3'($urandom);
      rule_port  = 3'($urandom);
      pri        = 8'($urandom);
      rule_index = 4'($urandom);
      add_pct    = (adds_sent < ROUTE_SLOTS) ? 25 : 3;
      pick       = $urandom_range(99);
      if (pick < 5) begin
         func = FUNC_UNUSED;
      end else if (pick < 5 + add_pct) begin
         func = FUNC_ADD;
         case ($urandom_range(4))
            0: mask = 16'hFFFF;
            1: mask = 16'hFF00;
            2: mask = 16'hFFF0;
            3: mask = 16'h0000;
            default: ;
         endcase
         if ($urandom_range(9) == 0) pri = NO_PRIORITY;
         rule_addr_pool.push_back(address);
         adds_sent++;
      end else if (pick < 20 + add_pct) begin
         func = FUNC_SET_PRI;
         if ($urandom_range(9) == 0) pri = NO_PRIORITY;
         else if ($urandom_range(9) == 0) pri = 8'd0;
      end else begin
         func = FUNC_ROUTE;
         pick = $urandom_range(99);
         if (pick < 12) begin
            address = cfg_own;
         end else if (pick < 22) begin
            address = cfg_alias;
         end else if (pick < 36) begin
            address = cfg_bcast;
         end else if (pick < 82 && rule_addr_pool.size() > 0) begin
            address = rule_addr_pool[$urandom_range(rule_addr_pool.size() - 1)];
            // Disturb the low bits now and then, which only rules whose masks clear those bits survive.
            if ($urandom_range(1) == 1) address[3:0] = 4'($urandom);
         end
      end
      send_word(func, address, mask, src_local, src_port, rule_port, pri, rule_index);
   endtask

   // Receiver: random back-pressure at its current rate, plus one long hold-off on request,
   // counted here in cycles while the sender keeps offering words.
   initial begin
      forever begin
         @(posedge clock);
         if (rx_hold_go) begin
            rx_hold_go = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Main stimulus: reset, directed words, then random phases under changing settings.
   initial begin
      logic [15:0] own;
      logic [15:0] alias_addr;
      logic [15:0] bcast;
      logic [7:0]  port_en;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: all ports disabled, empty table.
      send_word(FUNC_ROUTE, 16'h0000, 16'h0000, 1'b1, 3'd0, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'd257, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'hFFFF, 16'h0000, 1'b0, 3'd3, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0);
      // Priority on a slot that was never added is refused.
      send_word(FUNC_SET_PRI, 16'h0000, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd5, 4'd0);
      // The unused selector with every field at its top value.
      send_word(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7, 3'd7, 8'hFF, 4'hF);
      send_word(FUNC_ADD, 16'h1200, 16'hFF00, 1'b0, 3'd0, 3'd2, 8'd10, 4'd0);
      // The rule matches but its port is disabled.
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0);

      program_settings(16'd257, 16'd0, 16'hFFFF, 8'hFF);
      // Broadcast leaves out the arrival port, but not for a local source.
      send_word(FUNC_ROUTE, 16'hFFFF, 16'h0000, 1'b0, 3'd7, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'hFFFF, 16'h0000, 1'b1, 3'd2, 3'd0, 8'd0, 4'd0);
      // A rule at the never-used priority, and a catch-all default rule.
      send_word(FUNC_ADD, 16'h1234, 16'hFFFF, 1'b0, 3'd0, 3'd5, NO_PRIORITY, 4'd0);
      send_word(FUNC_ADD, 16'h0000, 16'h0000, 1'b0, 3'd0, 3'd7, 8'd200, 4'd0);
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0);
      // The best rule points back at the arrival port, so the next one wins.
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b0, 3'd2, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b1, 3'd2, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_SET_PRI, 16'h0000, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd1);
      send_word(FUNC_ROUTE, 16'h1234, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'hABCD, 16'h0000, 1'b0, 3'd7, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_SET_PRI, 16'h0000, 16'h0000, 1'b0, 3'd0, 3'd0, 8'd1, 4'hF);
      send_word(FUNC_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7, 3'd7, NO_PRIORITY, 4'hF);
      rule_addr_pool.push_back(16'h1200);
      rule_addr_pool.push_back(16'h1234);
      rule_addr_pool.push_back(16'h0000);
      rule_addr_pool.push_back(16'hFFFF);
      adds_sent = 4;

      // Own address equal to broadcast: the local check must win.
      program_settings(16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF);
      send_word(FUNC_ROUTE, 16'hFFFF, 16'h0000, 1'b1, 3'd0, 3'd0, 8'd0, 4'd0);
      send_word(FUNC_ROUTE, 16'hFFFF, 16'h0000, 1'b0, 3'd4, 3'd0, 8'd0, 4'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               own = 16'd257;  alias_addr = 16'd0;  bcast = 16'hFFFF;  port_en = 8'hFF;
            end
            1: begin
               own = 16'hFFFF; alias_addr = 16'h8000; bcast = 16'hFFFF;
               port_en = 8'($urandom);
            end
            2: begin
               own = 16'($urandom); alias_addr = 16'($urandom); bcast = 16'h0000;
               port_en = 8'h00;
            end
            3: begin
               own = 16'h0000; alias_addr = 16'h0000; bcast = 16'($urandom); port_en = 8'h81;
            end
            4: begin
               own = 16'($urandom); alias_addr = 16'($urandom); bcast = 16'($urandom);
               port_en = 8'($urandom);
            end
            default: begin
               own = 16'hAAAA; alias_addr = 16'hFFFF; bcast = 16'h0000; port_en = 8'hFF;
            end
         endcase
         program_settings(own, alias_addr, bcast, port_en);
         // Sender fast and receiver busy, then the reverse, then full speed both ways.
         if (phase < 2) begin
            tx_idle_pct = 15;
            rx_idle_pct = 57;
         end else if (phase < 4) begin
            tx_idle_pct = 57;
            rx_idle_pct = 15;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // A long receiver stall while words keep coming fills the unit up.
            if ((phase == 0 && n == 100) || (phase == 4 && n == 60)) rx_hold_go = 1;
            // And once per phase the sender waits for the unit to run empty.
            if (n == 150) drain();
            random_word();
         end
      end

      drain();
      repeat (ROUTE_SLOTS + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest correct run under the heaviest back-pressure.
   initial begin
      #6_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
